/* design/ptb_pkg.sv */
// ptb_pkg: shared constants, op codes and the slot control struct for the
// periodic / one-shot timer bank. No dependencies.
package ptb_pkg;

   // Number of timer slots (1..8) and counter width (8..32).
   localparam int SLOTS      = 8;
   localparam int COUNT_BITS = 32;

   // Fixed field widths of the request and response beats.
   localparam int OP_BITS     = 3;
   localparam int SLOT_BITS   = 4;
   localparam int PERIOD_BITS = 32;
   localparam int MASK_BITS   = 8;
   localparam int MASK_IDX    = 3;

   typedef enum logic [OP_BITS-1:0] {
      OP_TICK           = 3'd0,
      OP_START_PERIODIC = 3'd1,
      OP_START_ONE_SHOT = 3'd2,
      OP_STOP           = 3'd3,
      OP_CLEAR_ALL      = 3'd4
   } op_type;

   // Per-slot command for one accepted beat.
   typedef struct packed {
      logic tick;
      logic load;
      logic one_shot;
      logic enable_on_start;
      logic stop;
      logic clear;
   } slot_ctl_type;

endpackage

/* design/ptb_slot.sv */
// ptb_slot: one timer slot (reload value, down counter, one-shot mark,
// enable bit). Depends on ptb_pkg.
module ptb_slot (
   input  logic                             clock,
   input  logic                             reset,
   input  ptb_pkg::slot_ctl_type            ctl,
   input  logic [ptb_pkg::COUNT_BITS-1:0]   load_value,
   output logic                             enabled,
   output logic                             enabled_next,
   output logic                             fired
);

   logic                           enable_ff, enable_in;
   logic                           one_shot_ff, one_shot_in;
   logic [ptb_pkg::COUNT_BITS-1:0] reload_ff, reload_in;
   logic [ptb_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic                           count_zero;

   assign count_zero = (count_ff == '0);
   assign fired      = ctl.tick & enable_ff & count_zero;

   always_comb begin
      enable_in   = enable_ff;
      one_shot_in = one_shot_ff;
      reload_in   = reload_ff;
      count_in    = count_ff;
      if (ctl.clear) begin
         enable_in   = 1'b0;
         one_shot_in = 1'b0;
         reload_in   = '0;
         count_in    = '0;
      end else if (ctl.load) begin
         reload_in   = load_value;
         count_in    = load_value;
         one_shot_in = ctl.one_shot;
         if (ctl.enable_on_start) begin
            enable_in = 1'b1;
         end
      end else if (ctl.stop) begin
         enable_in = 1'b0;
      end else if (ctl.tick && enable_ff) begin
         if (count_zero) begin
            count_in = reload_ff;
            if (one_shot_ff) begin
               enable_in = 1'b0;
            end
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         one_shot_ff <= 1'b0;
         reload_ff   <= '0;
         count_ff    <= '0;
      end else begin
         enable_ff   <= enable_in;
         one_shot_ff <= one_shot_in;
         reload_ff   <= reload_in;
         count_ff    <= count_in;
      end
   end

   assign enabled      = enable_ff;
   assign enabled_next = enable_in;

endmodule

/* design/periodic_oneshot_timer_bank.sv */
// periodic_oneshot_timer_bank: top level of the timer bank, request decode
// and response register. Depends on ptb_pkg and ptb_slot.
//
// Usage:
//   Each req_ beat carries one op: tick, start periodic, start one-shot,
//   stop slot, or clear all. Every request beat produces exactly one rsp_
//   beat with the fired mask (nonzero only on a tick), the enable bits of
//   all slots after the op, and an accepted flag (0 for a start on a slot
//   out of range or already enabled, and for an unknown op code).
//   Latency: the response is valid the cycle after the request is taken.
//   Throughput: one beat per cycle unless stalled. All slots update in
//   parallel from their own compare-to-zero and decrement; the slot state
//   and the response register are the only stages, so req_ready stays
//   high while the response register is empty or drained the same cycle.
//   Stall: while rsp_valid is high and rsp_ready low, the response holds
//   and req_ready drops, so no request is taken and no slot state moves.
//   Reset: synchronous, active high; all slots disabled, reloads and
//   counters zeroed, response register empty. The bank is usable in the
//   first cycle after reset.
//   A slot fires once every period + 1 ticks: the tick that finds its
//   counter at zero reloads it rather than decrementing.
module periodic_oneshot_timer_bank (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ptb_pkg::OP_BITS-1:0]       req_op,
   input  logic [ptb_pkg::SLOT_BITS-1:0]     req_slot,
   input  logic [ptb_pkg::PERIOD_BITS-1:0]   req_period_ticks,
   input  logic                              req_start_enabled,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ptb_pkg::MASK_BITS-1:0]     rsp_fired_mask,
   output logic [ptb_pkg::MASK_BITS-1:0]     rsp_enabled_mask,
   output logic                              rsp_accepted
);

   localparam logic [ptb_pkg::SLOT_BITS-1:0] SlotLimit =
      ptb_pkg::SLOT_BITS'(ptb_pkg::SLOTS);

   logic                             req_fire;
   logic                             is_tick, is_start, is_stop, is_clear;
   logic                             one_shot;
   logic                             in_range;
   logic                             start_ok;
   logic                             accepted;
   logic [ptb_pkg::COUNT_BITS-1:0]   period_raw;
   logic [ptb_pkg::COUNT_BITS-1:0]   load_value;
   logic [ptb_pkg::MASK_BITS-1:0]    enabled_vec;
   logic [ptb_pkg::MASK_BITS-1:0]    enabled_next_vec;
   logic [ptb_pkg::MASK_BITS-1:0]    fired_vec;

   // Response register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ptb_pkg::MASK_BITS-1:0]    fired_ff;
   logic [ptb_pkg::MASK_BITS-1:0]    enabled_ff;
   logic                             accepted_ff;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire  = req_valid & req_ready;

   // Op decode
   always_comb begin
      is_tick  = 1'b0;
      is_start = 1'b0;
      is_stop  = 1'b0;
      is_clear = 1'b0;
      one_shot = 1'b0;
      case (ptb_pkg::op_type'(req_op))
         ptb_pkg::OP_TICK:           is_tick  = 1'b1;
         ptb_pkg::OP_START_PERIODIC: is_start = 1'b1;
         ptb_pkg::OP_START_ONE_SHOT: begin
            is_start = 1'b1;
            one_shot = 1'b1;
         end
         ptb_pkg::OP_STOP:           is_stop  = 1'b1;
         ptb_pkg::OP_CLEAR_ALL:      is_clear = 1'b1;
         default:                    ;
      endcase
   end

   // Start is refused out of range or on a running slot.
   assign in_range = (req_slot < SlotLimit);
   assign start_ok = is_start & in_range & ~enabled_vec[req_slot[ptb_pkg::MASK_IDX-1:0]];
   assign accepted = is_tick | is_stop | is_clear | start_ok;

   // Period kept to COUNT_BITS, zero taken as one.
   assign period_raw = req_period_ticks[ptb_pkg::COUNT_BITS-1:0];
   assign load_value = (period_raw == '0) ? ptb_pkg::COUNT_BITS'(1) : period_raw;

   // Slot lanes; mask bits above SLOTS read as zero.
   for (genvar i = 0; i < ptb_pkg::MASK_BITS; i++) begin : g_slot
      if (i < ptb_pkg::SLOTS) begin : g_live
         ptb_pkg::slot_ctl_type ctl;
         logic                  hit;

         assign hit = (req_slot == ptb_pkg::SLOT_BITS'(i));
         assign ctl.tick            = req_fire & is_tick;
         assign ctl.load            = req_fire & start_ok & hit;
         assign ctl.one_shot        = one_shot;
         assign ctl.enable_on_start = req_start_enabled;
         assign ctl.stop            = req_fire & is_stop & hit;
         assign ctl.clear           = req_fire & is_clear;

         ptb_slot u_slot (
            .clock        (clock),
            .reset        (reset),
            .ctl          (ctl),
            .load_value   (load_value),
            .enabled      (enabled_vec[i]),
            .enabled_next (enabled_next_vec[i]),
            .fired        (fired_vec[i])
         );
      end else begin : g_pad
         assign enabled_vec[i]      = 1'b0;
         assign enabled_next_vec[i] = 1'b0;
         assign fired_vec[i]        = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: loads only with a new beat.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         fired_ff    <= fired_vec;
         enabled_ff  <= enabled_next_vec;
         accepted_ff <= accepted;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fired_mask   = fired_ff;
   assign rsp_enabled_mask = enabled_ff;
   assign rsp_accepted     = accepted_ff;

   // Assertions
   a_fire_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_tick |=> rsp_fired_mask == '0)
      else $error("fired mask set on a non-tick op");

   a_fire_needs_enable: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_fired_mask & ~$past(enabled_vec)) == '0)
      else $error("disabled slot fired");

   a_unknown_op_rejected: assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_tick && !is_start && !is_stop && !is_clear |=> !rsp_accepted)
      else $error("unknown op accepted");

   a_clear_disables: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_clear |=> rsp_enabled_mask == '0 && enabled_vec == '0)
      else $error("clear-all left a slot enabled");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

/* sim/tb_periodic_oneshot_timer_bank.sv */
// tb_periodic_oneshot_timer_bank: self-checking bench for the timer bank.
// Uses ptb_pkg for widths and op codes, and the periodic_oneshot_timer_bank RTL.
// Directed and random req_ beats are scored against an in-bench model of the slots.
module tb_periodic_oneshot_timer_bank;
   timeunit 1ns;
   timeprecision 1ps;

   // Op codes the block must ignore (accepted = 0).
   localparam logic [ptb_pkg::OP_BITS-1:0] OP_RESERVED_FIRST = 3'd5;
   localparam logic [ptb_pkg::OP_BITS-1:0] OP_RESERVED_MID   = 3'd6;
   localparam logic [ptb_pkg::OP_BITS-1:0] OP_RESERVED_LAST  = 3'd7;

   // Cycles with no beat on either channel before the run is declared hung.
   localparam int STALL_LIMIT    = 1000;
   // Length of the forced receiver hold-off.
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int RANDOM_BEATS   = 500;

   typedef struct {
      logic [ptb_pkg::OP_BITS-1:0]     op;
      logic [ptb_pkg::SLOT_BITS-1:0]   slot;
      logic [ptb_pkg::PERIOD_BITS-1:0] period_ticks;
      logic                            start_enabled;
   } timer_req_type;

   typedef struct {
      logic [ptb_pkg::MASK_BITS-1:0] fired_mask;
      logic [ptb_pkg::MASK_BITS-1:0] enabled_mask;
      logic                          accepted;
   } timer_rsp_type;

   // Every input known from time zero.
   logic                            clock             = 1'b0;
   logic                            reset             = 1'b1;
   logic                            req_valid         = 1'b0;
   logic [ptb_pkg::OP_BITS-1:0]     req_op            = '0;
   logic [ptb_pkg::SLOT_BITS-1:0]   req_slot          = '0;
   logic [ptb_pkg::PERIOD_BITS-1:0] req_period_ticks  = '0;
   logic                            req_start_enabled = 1'b0;
   logic                            rsp_ready         = 1'b0;
   logic                            req_ready;
   logic                            rsp_valid;
   logic [ptb_pkg::MASK_BITS-1:0]   rsp_fired_mask;
   logic [ptb_pkg::MASK_BITS-1:0]   rsp_enabled_mask;
   logic                            rsp_accepted;

   periodic_oneshot_timer_bank uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_slot          (req_slot),
      .req_period_ticks  (req_period_ticks),
      .req_start_enabled (req_start_enabled),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_fired_mask    (rsp_fired_mask),
      .rsp_enabled_mask  (rsp_enabled_mask),
      .rsp_accepted      (rsp_accepted)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Slot model: mirrors the bank's store, advanced once per accepted beat.
   // ---------------------------------------------------------------------
   logic [ptb_pkg::MASK_BITS-1:0]  model_enable;
   logic [ptb_pkg::COUNT_BITS-1:0] model_reload   [ptb_pkg::SLOTS];
   logic [ptb_pkg::COUNT_BITS-1:0] model_count    [ptb_pkg::SLOTS];
   logic                           model_one_shot [ptb_pkg::SLOTS];

   // Responses still owed by the block, oldest first.
   timer_rsp_type pending_timer_rsps [$];

   int mismatch_count = 0;

   // Sender pacing: bursts of back-to-back beats separated by random gaps.
   int burst_left    = 0;
   bit steady_sender = 1'b0;

   // Receiver hold-off handshake between the test tasks and the rsp_ready process.
   int hold_off_requested = 0;
   int hold_off_served    = 0;
   int hold_off_left      = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   logic [5:0]  stall_phase   = '0;

   int idle_cycles = 0;

   function automatic void clear_slot_model();
      model_enable = '0;
      for (int i = 0; i < ptb_pkg::SLOTS; i++) begin
         model_reload[i]   = '0;
         model_count[i]    = '0;
         model_one_shot[i] = 1'b0;
      end
   endfunction

   // Applies one beat to the model and returns the response it must produce.
   function automatic timer_rsp_type predict_timer_bank(input timer_req_type beat);
      timer_rsp_type                  rsp;
      logic [ptb_pkg::COUNT_BITS-1:0] per;
      logic [ptb_pkg::MASK_IDX-1:0]   idx;
      rsp.fired_mask = '0;
      rsp.accepted   = 1'b1;
      idx            = beat.slot[ptb_pkg::MASK_IDX-1:0];
      case (beat.op)
         ptb_pkg::OP_TICK: begin
            for (int i = 0; i < ptb_pkg::SLOTS; i++) begin
               if (model_enable[i]) begin
                  // Zero means expiry: reload instead of decrementing.
                  if (model_count[i] == '0) begin
                     model_count[i] = model_reload[i];
                     if (model_one_shot[i])
                        model_enable[i] = 1'b0;
                     rsp.fired_mask[i] = 1'b1;
                  end else begin
                     model_count[i] = model_count[i] - 1'b1;
                  end
               end
            end
         end
         ptb_pkg::OP_START_PERIODIC, ptb_pkg::OP_START_ONE_SHOT: begin
            if (beat.slot >= ptb_pkg::SLOTS || model_enable[idx]) begin
               rsp.accepted = 1'b0;
            end else begin
               per = beat.period_ticks[ptb_pkg::COUNT_BITS-1:0];
               if (per == '0)
                  per = ptb_pkg::COUNT_BITS'(1);
               model_reload[idx]   = per;
               model_count[idx]    = per;
               model_one_shot[idx] = (beat.op == ptb_pkg::OP_START_ONE_SHOT);
               if (beat.start_enabled)
                  model_enable[idx] = 1'b1;
            end
         end
         ptb_pkg::OP_STOP: begin
            if (beat.slot < ptb_pkg::SLOTS)
               model_enable[idx] = 1'b0;
         end
         ptb_pkg::OP_CLEAR_ALL: clear_slot_model();
         default: rsp.accepted = 1'b0;
      endcase
      rsp.enabled_mask = model_enable;
      return rsp;
   endfunction

   function automatic timer_req_type make_beat(
         input logic [ptb_pkg::OP_BITS-1:0]     op,
         input logic [ptb_pkg::SLOT_BITS-1:0]   slot,
         input logic [ptb_pkg::PERIOD_BITS-1:0] period,
         input logic                            en);
      timer_req_type beat;
      beat.op            = op;
      beat.slot          = slot;
      beat.period_ticks  = period;
      beat.start_enabled = en;
      return beat;
   endfunction

   // Called at a rising edge. Opens a gap when the current burst runs out.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady_sender ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // Offers one beat and returns at the edge where it is taken. Valid is
   // left high so the next beat can follow with no bubble.
   task automatic send_beat(input timer_req_type beat);
      timer_rsp_type want;
      pace_sender();
      req_valid         <= 1'b1;
      req_op            <= beat.op;
      req_slot          <= beat.slot;
      req_period_ticks  <= beat.period_ticks;
      req_start_enabled <= beat.start_enabled;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = predict_timer_bank(beat);
      pending_timer_rsps.push_back(want);
   endtask

   // Sender goes quiet until every owed response has been scored.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_timer_rsps.size() != 0);
   endtask

   function automatic timer_req_type random_beat();
      timer_req_type beat;
      int            pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         beat.op = ptb_pkg::OP_TICK;
      else if (pick < 60)
         beat.op = ptb_pkg::OP_START_PERIODIC;
      else if (pick < 75)
         beat.op = ptb_pkg::OP_START_ONE_SHOT;
      else if (pick < 87)
         beat.op = ptb_pkg::OP_STOP;
      else if (pick < 90)
         beat.op = ptb_pkg::OP_CLEAR_ALL;
      else if (pick < 94)
         beat.op = ptb_pkg::OP_BITS'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
      else
         beat.op = ptb_pkg::OP_TICK;
      // Mostly legal slots; a tenth lands out of range.
      beat.slot = ($urandom_range(0, 9) == 0)
                  ? ptb_pkg::SLOT_BITS'($urandom_range(8, 15))
                  : ptb_pkg::SLOT_BITS'($urandom_range(0, ptb_pkg::SLOTS - 1));
      // Short periods keep slots firing; the rest are random, zero or all ones.
      case ($urandom_range(0, 9))
         7:       beat.period_ticks = $urandom;
         8:       beat.period_ticks = '0;
         9:       beat.period_ticks = '1;
         default: beat.period_ticks = $urandom_range(0, 6);
      endcase
      beat.start_enabled = ($urandom_range(0, 4) != 0);
      return beat;
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: rsp_ready steps through a 16-bit pattern, re-rolled whenever
   // stall_phase wraps; a requested hold-off overrides it for a long stretch.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_off_requested != hold_off_served) begin
         hold_off_served <= hold_off_requested;
         hold_off_left   <= HOLD_OFF_CYCLES;
         rsp_ready       <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_ready     <= 1'b0;
      end else begin
         stall_phase <= stall_phase + 1'b1;
         if (stall_phase == '1) begin
            case ($urandom_range(0, 3))
               0:       stall_pattern <= 16'hFFFF;
               1:       stall_pattern <= 16'($urandom);
               2:       stall_pattern <= 16'hAAAA;
               default: stall_pattern <= 16'($urandom | $urandom);
            endcase
         end
         rsp_ready <= stall_pattern[stall_phase[3:0]];
      end
   end

   // ---------------------------------------------------------------------
   // Scoreboard: each rsp beat against the oldest owed response.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      timer_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_timer_rsps.size() == 0) begin
            $error("rsp beat with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_timer_rsps.pop_front();
            if (rsp_fired_mask !== want.fired_mask) begin
               $error("fired_mask: expected %h, got %h", want.fired_mask, rsp_fired_mask);
               mismatch_count++;
            end
            if (rsp_enabled_mask !== want.enabled_mask) begin
               $error("enabled_mask: expected %h, got %h", want.enabled_mask,
                      rsp_enabled_mask);
               mismatch_count++;
            end
            if (rsp_accepted !== want.accepted) begin
               $error("accepted: expected %b, got %b", want.accepted, rsp_accepted);
               mismatch_count++;
            end
         end
      end
   end

   // Hang detector: no beat on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[periodic_oneshot_timer_bank] ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Empty bank, rejected starts, out-of-range stops, reserved op codes.
   task automatic test_idle_and_rejects();
      send_beat(make_beat(ptb_pkg::OP_TICK, 4'd0, '0, 1'b0));
      send_beat(make_beat(ptb_pkg::OP_START_PERIODIC, 4'd8, 32'd3, 1'b1));
      send_beat(make_beat(ptb_pkg::OP_START_ONE_SHOT, 4'd15, '1, 1'b1));
      send_beat(make_beat(ptb_pkg::OP_STOP, 4'd12, '0, 1'b0));
      send_beat(make_beat(ptb_pkg::OP_STOP, 4'd5, '0, 1'b0));
      send_beat(make_beat(OP_RESERVED_FIRST, 4'd0, 32'd1, 1'b1));
      send_beat(make_beat(OP_RESERVED_MID, 4'd3, '1, 1'b0));
      send_beat(make_beat(OP_RESERVED_LAST, 4'd15, '1, 1'b1));
   endtask

   // Period zero forced to one, one-shot self-disable, configure-only start,
   // double start, periodic restart of a former one-shot slot, clear-all.
   task automatic test_firing_and_modes();
      send_beat(make_beat(ptb_pkg::OP_START_PERIODIC, 4'd0, '0, 1'b1));
      send_beat(make_beat(ptb_pkg::OP_START_ONE_SHOT, 4'd7, 32'd2, 1'b1));
      send_beat(make_beat(ptb_pkg::OP_START_PERIODIC, 4'd0, 32'd5, 1'b1));
      send_beat(make_beat(ptb_pkg::OP_START_PERIODIC, 4'd3, '1, 1'b0));
      repeat (4) send_beat(make_beat(ptb_pkg::OP_TICK, 4'd0, '0, 1'b0));
      send_beat(make_beat(ptb_pkg::OP_START_PERIODIC, 4'd7, 32'd1, 1'b1));
      repeat (4) send_beat(make_beat(ptb_pkg::OP_TICK, 4'd0, '0, 1'b0));
      send_beat(make_beat(ptb_pkg::OP_STOP, 4'd0, '0, 1'b0));
      send_beat(make_beat(ptb_pkg::OP_TICK, 4'd0, '0, 1'b0));
      send_beat(make_beat(ptb_pkg::OP_CLEAR_ALL, 4'd0, '0, 1'b0));
      send_beat(make_beat(ptb_pkg::OP_TICK, 4'd0, '0, 1'b0));
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps offering back to back, so
   // the response register fills and req_ready must drop.
   task automatic test_full_backpressure();
      steady_sender = 1'b1;
      hold_off_requested++;
      for (int i = 0; i < 30; i++)
         send_beat(random_beat());
      wait_drained();
      steady_sender = 1'b0;
   endtask

   task automatic test_random_traffic();
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 60 == 0)
            steady_sender = ($urandom_range(0, 3) == 0);
         if (i % 137 == 136)
            wait_drained();
         send_beat(random_beat());
      end
      steady_sender = 1'b0;
      wait_drained();
   endtask

   initial begin
      clear_slot_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_idle_and_rejects();
      test_firing_and_modes();
      test_full_backpressure();
      test_random_traffic();
      // Trailing idle edges catch any stray rsp beat.
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_timer_rsps.size() == 0)
         $display("[periodic_oneshot_timer_bank] OK");
      else
         $display("[periodic_oneshot_timer_bank] ERROR");
      $finish;
   end

endmodule
